// ===== hdl/lpht_pkg.sv =====
package lpht_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned DATA_W  = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_REMOVED   = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        t_req_type          req_type;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  read_value;
    } t_rsp;

    typedef struct packed {
        logic               used;
        logic               tomb;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

// ===== hdl/lpht_mod.sv =====
module lpht_mod #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpht_pkg::KEY_W-1:0]    i_key,
    output logic                          o_done,
    output logic [AW-1:0]                 o_rem
);

    // quotient = key * ceil(2^(KEY_W+AW) / SLOTS) >> (KEY_W+AW), exact for every key
    localparam int unsigned SHIFT = lpht_pkg::KEY_W + AW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [lpht_pkg::KEY_W:0] RECIP = RECIP_FULL[lpht_pkg::KEY_W:0];
    localparam logic [AW-1:0] SLOTS_LO = AW'(SLOTS);

    logic [lpht_pkg::KEY_W-1:0]   r_key;
    logic                         r_key_vld;
    logic [AW-1:0]                r_q_lo;
    logic                         r_q_vld;
    logic [AW-1:0]                r_rem;
    logic                         r_done;
    logic [2*lpht_pkg::KEY_W:0]   w_prod;
    logic [AW-1:0]                w_qm;
    logic [AW-1:0]                w_rem;

    assign w_prod = {{(lpht_pkg::KEY_W+1){1'b0}}, r_key} *
                    {{lpht_pkg::KEY_W{1'b0}}, RECIP};

    // remainder is below 2^AW, so only the low AW bits of key and quotient matter
    assign w_qm  = r_q_lo * SLOTS_LO;
    assign w_rem = r_key[AW-1:0] - w_qm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= 1'b0;
            r_q_vld   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_key_vld <= i_start;
            r_q_vld   <= r_key_vld;
            r_done    <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        r_q_lo <= w_prod[SHIFT +: AW];
        r_rem  <= w_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/lpht_mem.sv =====
module lpht_mem #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  lpht_pkg::t_slot        i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output lpht_pkg::t_slot        o_rdata
);

    lpht_pkg::t_slot r_mem [SLOTS];
    lpht_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lpht_ctrl.sv =====
module lpht_ctrl #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  lpht_pkg::t_req         i_req,
    output logic                   o_busy,
    output logic                   o_mod_start,
    input  logic                   i_mod_done,
    input  logic [AW-1:0]          i_mod_rem,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output lpht_pkg::t_slot        o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  lpht_pkg::t_slot        i_mem_rdata,
    output logic                   o_done,
    output lpht_pkg::t_rsp         o_rsp
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    lpht_pkg::t_state              r_state, n_state;
    lpht_pkg::t_req                r_req, n_req;
    logic [AW-1:0]                 r_cur, n_cur;
    logic [AW-1:0]                 r_cnt, n_cnt;
    logic                          r_hit, n_hit;
    logic [AW-1:0]                 r_hit_slot, n_hit_slot;
    logic [lpht_pkg::DATA_W-1:0]   r_hit_data, n_hit_data;
    logic                          r_have_free, n_have_free;
    logic [AW-1:0]                 r_free_slot, n_free_slot;
    logic                          r_done, n_done;
    lpht_pkg::t_rsp                r_rsp, n_rsp;
    logic                          w_accept;
    logic [AW-1:0]                 w_next;
    logic                          w_ent_hit;

    assign w_accept  = i_start && (r_state == lpht_pkg::S_IDLE);
    assign w_next    = (r_cur == LAST_SLOT) ? '0 : r_cur + AW'(1);
    assign w_ent_hit = i_mem_rdata.used && (i_mem_rdata.key == r_req.key);

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_cur        = r_cur;
        n_cnt        = r_cnt;
        n_hit        = r_hit;
        n_hit_slot   = r_hit_slot;
        n_hit_data   = r_hit_data;
        n_have_free  = r_have_free;
        n_free_slot  = r_free_slot;
        n_done       = 1'b0;
        n_rsp        = r_rsp;
        o_mod_start  = 1'b0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_cur;
        o_mem_wdata  = '0;
        o_mem_raddr  = r_cur;

        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                // sweep every slot to never-used
                o_mem_we = 1'b1;
                n_cur    = r_cur + AW'(1);
                if (r_cur == LAST_SLOT) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_req       = i_req;
                    n_hit       = 1'b0;
                    n_have_free = 1'b0;
                    if (i_req.req_type == lpht_pkg::REQ_INSERT ||
                        i_req.req_type == lpht_pkg::REQ_SEARCH ||
                        i_req.req_type == lpht_pkg::REQ_REMOVE) begin
                        o_mod_start = 1'b1;
                        n_state     = lpht_pkg::S_MOD;
                    end else begin
                        n_state = lpht_pkg::S_DONE;
                    end
                end
            end
            lpht_pkg::S_MOD: begin
                if (i_mod_done) begin
                    o_mem_raddr = i_mod_rem;
                    n_cur       = i_mod_rem;
                    n_cnt       = '0;
                    n_state     = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE: begin
                if (!i_mem_rdata.used && !r_have_free) begin
                    n_have_free = 1'b1;
                    n_free_slot = r_cur;
                end
                priority if (w_ent_hit) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_cur;
                    n_hit_data = i_mem_rdata.data;
                    n_state    = lpht_pkg::S_DONE;
                end else if ((!i_mem_rdata.used && !i_mem_rdata.tomb) ||
                             (r_cnt == LAST_SLOT)) begin
                    n_state = lpht_pkg::S_DONE;
                end else begin
                    // advance to the next slot, wrapping at the end
                    n_cur       = w_next;
                    n_cnt       = r_cnt + AW'(1);
                    o_mem_raddr = w_next;
                end
            end
            lpht_pkg::S_DONE: begin
                n_done           = 1'b1;
                n_rsp.status     = lpht_pkg::STAT_NOT_FOUND;
                n_rsp.read_value = '0;
                o_mem_wdata.used = 1'b1;
                o_mem_wdata.tomb = 1'b0;
                o_mem_wdata.key  = r_req.key;
                o_mem_wdata.data = r_req.value;
                n_state          = lpht_pkg::S_IDLE;
                unique case (r_req.req_type)
                    lpht_pkg::REQ_INSERT: begin
                        if (r_hit) begin
                            o_mem_we     = 1'b1;
                            o_mem_waddr  = r_hit_slot;
                            n_rsp.status = lpht_pkg::STAT_UPDATED;
                        end else if (r_have_free) begin
                            o_mem_we     = 1'b1;
                            o_mem_waddr  = r_free_slot;
                            n_rsp.status = lpht_pkg::STAT_INSERTED;
                        end else begin
                            n_rsp.status = lpht_pkg::STAT_FULL;
                        end
                    end
                    lpht_pkg::REQ_SEARCH: begin
                        if (r_hit) begin
                            n_rsp.status     = lpht_pkg::STAT_FOUND;
                            n_rsp.read_value = r_hit_data;
                        end
                    end
                    lpht_pkg::REQ_REMOVE: begin
                        if (r_hit) begin
                            o_mem_we         = 1'b1;
                            o_mem_waddr      = r_hit_slot;
                            o_mem_wdata.used = 1'b0;
                            o_mem_wdata.tomb = 1'b1;
                            n_rsp.status     = lpht_pkg::STAT_REMOVED;
                        end
                    end
                    default: begin
                        n_rsp.status = lpht_pkg::STAT_NOT_FOUND;
                    end
                endcase
            end
            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_CLEAR;
            r_cur       <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_cnt       <= n_cnt;
            r_hit       <= n_hit;
            r_have_free <= n_have_free;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_hit_slot  <= n_hit_slot;
        r_hit_data  <= n_hit_data;
        r_free_slot <= n_free_slot;
        r_rsp       <= n_rsp;
    end

    assign o_busy = (r_state != lpht_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == lpht_pkg::S_DONE))
        else $error("result strobe without a finished request");

    a_no_write_while_probing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpht_pkg::S_PROBE || r_state == lpht_pkg::S_MOD) |-> !o_mem_we)
        else $error("table written during a probe");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not raise busy");

    a_insert_wrote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == lpht_pkg::STAT_INSERTED ||
                    o_rsp.status == lpht_pkg::STAT_UPDATED ||
                    o_rsp.status == lpht_pkg::STAT_REMOVED)) |-> $past(o_mem_we))
        else $error("table change reported without a write");

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing over TABLE_SLOTS slots held in one
// synchronous RAM. Raise i_start with a request while o_busy is low; exactly one
// result comes back on o_rsp, qualified by o_done for a single cycle, and the
// receiver must take it then since the block cannot stall. A request is handled in
// order: key modulo TABLE_SLOTS is computed by reciprocal multiplication, the
// home-slot read is issued, the probe reads one slot per cycle through the single
// RAM read port and covers 1 to TABLE_SLOTS slots, then the write-back is done and
// the registered result is formed and presented. o_busy is already low while the
// result is presented, so the next request can transfer at the edge that takes the
// result. An unknown request code skips the modulo and probe and answers "not
// found". After reset o_busy stays high while every slot is cleared to never-used.
module linear_probe_hash_table #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lpht_pkg::t_req    i_req,
    output logic              o_busy,
    output logic              o_done,
    output lpht_pkg::t_rsp    o_rsp
);

    localparam int unsigned AW = $clog2(TABLE_SLOTS);

    logic              w_mod_start;
    logic              w_mod_done;
    logic [AW-1:0]     w_mod_rem;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    lpht_pkg::t_slot   w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;
    lpht_pkg::t_slot   w_mem_rdata;

    lpht_mod #(
        .SLOTS (TABLE_SLOTS),
        .AW    (AW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_key   (i_req.key),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    lpht_mem #(
        .SLOTS (TABLE_SLOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    lpht_ctrl #(
        .SLOTS (TABLE_SLOTS),
        .AW    (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_mod_start (w_mod_start),
        .i_mod_done  (w_mod_done),
        .i_mod_rem   (w_mod_rem),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== verif/linear_probe_hash_table_tb.sv =====
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;

    localparam int unsigned SLOTS       = 16;
    localparam int          CLK_HALF    = 2;
    localparam int          RESET_CYCLES = 6;
    // longest request: modulo pass, a walk over every slot, write-back
    localparam int          TAIL_CYCLES = 64;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          GAP_MAX     = 19;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          PHASE_ITEMS = 50;
    // request code outside the decoded set
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    lpht_pkg::t_req   i_req   = '0;
    logic             o_busy;
    logic             o_done;
    lpht_pkg::t_rsp   o_rsp;

    linear_probe_hash_table #(
        .TABLE_SLOTS (SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // mirror of the table contents
    logic [lpht_pkg::KEY_W-1:0]  tbl_key  [SLOTS];
    logic [lpht_pkg::DATA_W-1:0] tbl_data [SLOTS];
    bit                          tbl_used [SLOTS];
    bit                          tbl_tomb [SLOTS];

    lpht_pkg::t_rsp  pending_rsp_q[$];
    int    fail_cnt  = 0;
    int    cycle_cnt = 0;
    int    gap_limit = GAP_MAX;

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Walk the chain of the key and apply the request to the mirror.
    function automatic lpht_pkg::t_rsp hash_table_result(input lpht_pkg::t_req req);
        lpht_pkg::t_rsp rsp;
        int          hit;
        int          free_at;
        int unsigned slot;
        bit          stop;
        rsp.status     = lpht_pkg::STAT_NOT_FOUND;
        rsp.read_value = '0;
        hit     = -1;
        free_at = -1;
        stop    = 1'b0;
        slot    = req.key % SLOTS;
        if (req.req_type != REQ_UNKNOWN) begin
            for (int n = 0; n < SLOTS && !stop; n++) begin
                if (!tbl_used[slot]) begin
                    if (free_at < 0) free_at = slot;
                    // a never-used slot ends the chain
                    if (!tbl_tomb[slot]) stop = 1'b1;
                end else if (tbl_key[slot] == req.key) begin
                    hit  = slot;
                    stop = 1'b1;
                end
                slot = (slot + 1 >= SLOTS) ? 0 : slot + 1;
            end
        end
        case (req.req_type)
            lpht_pkg::REQ_INSERT: begin
                if (hit >= 0) begin
                    tbl_data[hit] = req.value;
                    rsp.status    = lpht_pkg::STAT_UPDATED;
                end else if (free_at >= 0) begin
                    tbl_key[free_at]  = req.key;
                    tbl_data[free_at] = req.value;
                    tbl_used[free_at] = 1'b1;
                    tbl_tomb[free_at] = 1'b0;
                    rsp.status        = lpht_pkg::STAT_INSERTED;
                end else begin
                    rsp.status = lpht_pkg::STAT_FULL;
                end
            end
            lpht_pkg::REQ_SEARCH: begin
                if (hit >= 0) begin
                    rsp.read_value = tbl_data[hit];
                    rsp.status     = lpht_pkg::STAT_FOUND;
                end
            end
            lpht_pkg::REQ_REMOVE: begin
                if (hit >= 0) begin
                    tbl_used[hit] = 1'b0;
                    tbl_tomb[hit] = 1'b1;
                    rsp.status    = lpht_pkg::STAT_REMOVED;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Start stays high between back-to-back requests; lower it only for a gap.
    task automatic send_req(input lpht_pkg::t_req_type kind,
                            input logic [lpht_pkg::KEY_W-1:0] key,
                            input logic [lpht_pkg::DATA_W-1:0] data);
        lpht_pkg::t_req req;
        int   gap;
        req.req_type = kind;
        req.key      = key;
        req.value    = data;
        gap = $urandom_range(0, gap_limit);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_busy);
        pending_rsp_q.push_back(hash_table_result(req));
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : rsp_check
        lpht_pkg::t_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            if (pending_rsp_q.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_rsp.status);
                fail_cnt++;
            end else begin
                exp_rsp = pending_rsp_q.pop_front();
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d", exp_rsp.status, o_rsp.status);
                    fail_cnt++;
                end
                if (o_rsp.read_value !== exp_rsp.read_value) begin
                    $error("read_value: expected %08h, actual %08h",
                           exp_rsp.read_value, o_rsp.read_value);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        gap_limit = GAP_MAX;
        // misses on the empty table
        send_req(lpht_pkg::REQ_SEARCH, 32'h0000_0005, 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, 32'h0000_0005, 32'hFFFF_FFFF);
        send_req(lpht_pkg::t_req_type'(REQ_UNKNOWN), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // extremes, then collisions around the wrap point
        send_req(lpht_pkg::REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_req(lpht_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(lpht_pkg::REQ_INSERT, 32'h0000_0010, 32'h1234_5678);
        send_req(lpht_pkg::REQ_INSERT, 32'h0000_001F, 32'h8765_4321);
        send_req(lpht_pkg::REQ_SEARCH, 32'h0000_001F, 32'h0);
        send_req(lpht_pkg::REQ_INSERT, 32'h0000_0000, 32'hAAAA_5555);
        send_req(lpht_pkg::REQ_SEARCH, 32'h0000_0000, 32'h0);
        // tombstone in the middle of a chain
        send_req(lpht_pkg::REQ_REMOVE, 32'h0000_0010, 32'h0);
        send_req(lpht_pkg::REQ_SEARCH, 32'h0000_001F, 32'h0);
        send_req(lpht_pkg::REQ_INSERT, 32'h0000_0020, 32'h5555_AAAA);
        send_req(lpht_pkg::REQ_SEARCH, 32'h0000_0020, 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, 32'h0000_0020, 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, 32'h0000_0020, 32'h0);
        send_req(lpht_pkg::REQ_INSERT, 32'h0000_001F, 32'h0000_0001);
        send_req(lpht_pkg::REQ_SEARCH, 32'hFFFF_FFFF, 32'h0);
        send_req(lpht_pkg::t_req_type'(REQ_UNKNOWN), 32'h0000_0000, 32'hFFFF_FFFF);
        send_req(lpht_pkg::REQ_SEARCH, 32'h0000_0000, 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, 32'h0000_0000, 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, 32'h0000_001F, 32'h0);
        wait_idle();
    endtask

    task automatic test_full_table();
        logic [lpht_pkg::KEY_W-1:0] live_keys[$];
        logic [lpht_pkg::KEY_W-1:0] chain_keys[SLOTS];
        int                         home;
        home = $urandom_range(0, SLOTS - 1);
        gap_limit = GAP_MAX;
        for (int s = 0; s < SLOTS; s++) begin
            if (tbl_used[s]) live_keys.push_back(tbl_key[s]);
        end
        foreach (live_keys[i]) send_req(lpht_pkg::REQ_REMOVE, live_keys[i], $urandom);
        // one chain that covers every slot and wraps
        for (int i = 0; i < SLOTS; i++) begin
            chain_keys[i] = {24'($urandom), 4'(i), 4'(home)};
            send_req(lpht_pkg::REQ_INSERT, chain_keys[i], $urandom);
        end
        send_req(lpht_pkg::REQ_INSERT,
                 {24'($urandom), 4'hF, 4'(home + 1)} ^ 32'h8000_0000, $urandom);
        send_req(lpht_pkg::REQ_INSERT, chain_keys[SLOTS - 1], $urandom);
        send_req(lpht_pkg::REQ_SEARCH, chain_keys[SLOTS - 1], 32'h0);
        send_req(lpht_pkg::REQ_SEARCH, ~chain_keys[0], 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, ~chain_keys[0], 32'h0);
        for (int i = 0; i < SLOTS; i++) send_req(lpht_pkg::REQ_REMOVE, chain_keys[i], 32'h0);
        // every slot is now a tombstone
        send_req(lpht_pkg::REQ_SEARCH, chain_keys[3], 32'h0);
        send_req(lpht_pkg::REQ_INSERT, chain_keys[7], 32'hC0DE_0007);
        send_req(lpht_pkg::REQ_SEARCH, chain_keys[7], 32'h0);
        send_req(lpht_pkg::REQ_REMOVE, chain_keys[7], 32'h0);
        // hold off until the table has answered everything
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [lpht_pkg::KEY_W-1:0] key_pool[24];
        logic [lpht_pkg::KEY_W-1:0] key;
        lpht_pkg::t_req_type        kind;
        int                         hot;
        int                         pick;
        for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
            gap_limit = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            if (phase % 3 == 0) begin
                hot = $urandom_range(0, SLOTS - 1);
                // cluster most keys on two home slots to build long chains
                foreach (key_pool[i]) begin
                    key_pool[i] = $urandom;
                    if ($urandom_range(0, 9) < 6)
                        key_pool[i][3:0] = 4'(hot + $urandom_range(0, 1));
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      kind = lpht_pkg::REQ_INSERT;
                else if (pick < 75) kind = lpht_pkg::REQ_SEARCH;
                else if (pick < 95) kind = lpht_pkg::REQ_REMOVE;
                else                kind = lpht_pkg::t_req_type'(REQ_UNKNOWN);
                key = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, 23)];
                send_req(kind, key, $urandom);
            end
            if (phase == 6) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            tbl_key[s]  = '0;
            tbl_data[s] = '0;
            tbl_used[s] = 1'b0;
            tbl_tomb[s] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_random_traffic();
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
